@@ src/counting_semaphore_unit_assert.svh @@
// assertion macros for the counting semaphore unit
`ifndef COUNTING_SEMAPHORE_UNIT_ASSERT_SVH
`define COUNTING_SEMAPHORE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define CSU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define CSU_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CSU_ASSERT(lbl, prop, msg)
`define CSU_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ src/csu_pkg.sv @@
package csu_pkg;

	localparam int NUM_SEMS    = 16;
	localparam int QUEUE_DEPTH = 16;
	localparam int PID_BITS    = 8;

	localparam int CNT_BITS  = 16;
	localparam int SEM_BITS  = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
	localparam int QPTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FILL_BITS = $clog2(QUEUE_DEPTH + 1);
	localparam int MEM_DEPTH = NUM_SEMS * QUEUE_DEPTH;
	localparam int ADDR_BITS = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	// command queue between front and back
	localparam int CQ_DEPTH    = 2;
	localparam int CQ_PTR_BITS = $clog2(CQ_DEPTH);
	localparam int CQ_CNT_BITS = $clog2(CQ_DEPTH + 1);

	localparam logic signed [CNT_BITS-1:0] COUNT_MAX = {1'b0, {(CNT_BITS-1){1'b1}}};
	localparam logic signed [CNT_BITS-1:0] COUNT_MIN = {1'b1, {(CNT_BITS-1){1'b0}}};

	typedef enum logic [1:0] {
		OP_CREATE = 2'd0,
		OP_WAIT   = 2'd1,
		OP_SIGNAL = 2'd2
	} op_code_t;

	typedef enum logic [3:0] {
		STAT_CREATED  = 4'd0,
		STAT_EXISTS   = 4'd1,
		STAT_ACQUIRED = 4'd2,
		STAT_BLOCKED  = 4'd3,
		STAT_UNKNOWN  = 4'd4,
		STAT_DEAD     = 4'd5,
		STAT_RELEASED = 4'd6,
		STAT_WOKE     = 4'd7,
		STAT_QFULL    = 4'd8
	} status_t;

	typedef enum logic [1:0] {
		CMD_CREATE,
		CMD_WAIT,
		CMD_SIGNAL,
		CMD_FIXED
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                   kind;
		status_t                     fixed_status;
		logic [SEM_BITS-1:0]         slot;
		logic [PID_BITS-1:0]         pid;
		logic signed [CNT_BITS-1:0]  init;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_EXEC,
		BK_RESP
	} bk_state_t;

endpackage

@@ src/csu_front.sv @@
module csu_front import csu_pkg::*; (
	input  logic                req_valid,
	output logic                req_stall,
	input  logic [1:0]          operation,
	input  logic [3:0]          sem_index,
	input  logic [7:0]          pid,
	input  logic signed [15:0]  init_value,
	input  logic                process_alive,
	input  logic                q_full,
	output logic                q_push,
	output cmd_t                q_cmd
);

	logic in_range;

	assign in_range  = (32'(sem_index) < NUM_SEMS);
	assign req_stall = q_full;
	assign q_push    = req_valid && !q_full;

	always_comb begin
		q_cmd.kind         = CMD_FIXED;
		q_cmd.fixed_status = STAT_UNKNOWN;
		q_cmd.slot         = SEM_BITS'(sem_index);
		q_cmd.pid          = PID_BITS'(pid);
		q_cmd.init         = CNT_BITS'(init_value);
		case (operation)
			OP_CREATE: begin
				if (in_range) q_cmd.kind = CMD_CREATE;
			end
			OP_WAIT: begin
				// a dead process is refused before the slot is looked at
				if (!process_alive) q_cmd.fixed_status = STAT_DEAD;
				else if (in_range) q_cmd.kind = CMD_WAIT;
			end
			OP_SIGNAL: begin
				if (in_range) q_cmd.kind = CMD_SIGNAL;
			end
			default: begin
				q_cmd.kind = CMD_FIXED;
			end
		endcase
	end

endmodule

@@ src/csu_cmd_fifo.sv @@
module csu_cmd_fifo import csu_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  cmd_t  push_cmd,
	output logic  full,
	input  logic  pop,
	output logic  not_empty,
	output cmd_t  head_cmd
);

	cmd_t                   entry_q [CQ_DEPTH];
	logic [CQ_PTR_BITS-1:0] wr_ptr_q;
	logic [CQ_PTR_BITS-1:0] rd_ptr_q;
	logic [CQ_CNT_BITS-1:0] count_q;

	assign full      = (count_q == CQ_CNT_BITS'(CQ_DEPTH));
	assign not_empty = (count_q != '0);
	assign head_cmd  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == CQ_PTR_BITS'(CQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == CQ_PTR_BITS'(CQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

@@ src/csu_back.sv @@
module csu_back import csu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_not_empty,
	input  cmd_t        q_cmd,
	output logic        q_pop,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [3:0]  status,
	output logic [7:0]  woken_pid
);

	bk_state_t state_q, state_d;
	logic      out_load;

	cmd_t      cmd_s1;
	status_t   status_s2;

	logic                        exists_q [NUM_SEMS];
	logic signed [CNT_BITS-1:0]  count_q  [NUM_SEMS];
	logic [QPTR_BITS-1:0]        head_q   [NUM_SEMS];
	logic [QPTR_BITS-1:0]        tail_q   [NUM_SEMS];
	logic [FILL_BITS-1:0]        fill_q   [NUM_SEMS];

	logic [PID_BITS-1:0] wait_mem [MEM_DEPTH];
	logic [PID_BITS-1:0] mem_rd_q;

	logic                rsp_valid_q;
	status_t             status_q;
	logic [7:0]          woken_pid_q;

	// per-transaction working values
	logic                        exec_en;
	logic                        cur_exists;
	logic signed [CNT_BITS-1:0]  cur_count;
	logic [QPTR_BITS-1:0]        cur_head;
	logic [QPTR_BITS-1:0]        cur_tail;
	logic [FILL_BITS-1:0]        cur_fill;
	logic signed [CNT_BITS-1:0]  dec_count;
	logic signed [CNT_BITS-1:0]  inc_count;
	logic [QPTR_BITS-1:0]        head_inc;
	logic [QPTR_BITS-1:0]        tail_inc;
	logic [ADDR_BITS-1:0]        slot_base;

	status_t                     exec_status;
	logic                        upd_slot;
	logic                        new_exists;
	logic signed [CNT_BITS-1:0]  new_count;
	logic [QPTR_BITS-1:0]        new_head;
	logic [QPTR_BITS-1:0]        new_tail;
	logic [FILL_BITS-1:0]        new_fill;
	logic                        mem_we;
	logic [ADDR_BITS-1:0]        mem_addr;

	assign exec_en    = (state_q == BK_EXEC);
	assign cur_exists = exists_q[cmd_s1.slot];
	assign cur_count  = count_q[cmd_s1.slot];
	assign cur_head   = head_q[cmd_s1.slot];
	assign cur_tail   = tail_q[cmd_s1.slot];
	assign cur_fill   = fill_q[cmd_s1.slot];

	assign dec_count = (cur_count == COUNT_MIN) ? COUNT_MIN : cur_count - CNT_BITS'(1);
	assign inc_count = (cur_count == COUNT_MAX) ? COUNT_MAX : cur_count + CNT_BITS'(1);
	assign head_inc  = (cur_head == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : cur_head + 1'b1;
	assign tail_inc  = (cur_tail == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : cur_tail + 1'b1;
	assign slot_base = ADDR_BITS'(cmd_s1.slot) * ADDR_BITS'(QUEUE_DEPTH);

	always_comb begin
		exec_status = cmd_s1.fixed_status;
		upd_slot    = 1'b0;
		new_exists  = cur_exists;
		new_count   = cur_count;
		new_head    = cur_head;
		new_tail    = cur_tail;
		new_fill    = cur_fill;
		mem_we      = 1'b0;
		mem_addr    = slot_base + ADDR_BITS'(cur_head);
		case (cmd_s1.kind)
			CMD_CREATE: begin
				if (cur_exists) begin
					exec_status = STAT_EXISTS;
				end else begin
					exec_status = STAT_CREATED;
					upd_slot    = 1'b1;
					new_exists  = 1'b1;
					new_count   = cmd_s1.init;
					new_head    = '0;
					new_tail    = '0;
					new_fill    = '0;
				end
			end
			CMD_WAIT: begin
				if (!cur_exists) begin
					exec_status = STAT_UNKNOWN;
				end else if (dec_count < 0) begin
					if (cur_fill == FILL_BITS'(QUEUE_DEPTH)) begin
						exec_status = STAT_QFULL;
					end else begin
						exec_status = STAT_BLOCKED;
						upd_slot    = 1'b1;
						new_count   = dec_count;
						new_tail    = tail_inc;
						new_fill    = cur_fill + 1'b1;
						mem_we      = 1'b1;
						mem_addr    = slot_base + ADDR_BITS'(cur_tail);
					end
				end else begin
					exec_status = STAT_ACQUIRED;
					upd_slot    = 1'b1;
					new_count   = dec_count;
				end
			end
			CMD_SIGNAL: begin
				if (!cur_exists) begin
					exec_status = STAT_UNKNOWN;
				end else begin
					upd_slot  = 1'b1;
					new_count = inc_count;
					if (inc_count <= 0 && cur_fill != '0) begin
						// oldest waiter leaves the queue; its pid is read this cycle
						exec_status = STAT_WOKE;
						new_head    = head_inc;
						new_fill    = cur_fill - 1'b1;
					end else begin
						exec_status = STAT_RELEASED;
					end
				end
			end
			default: begin
				exec_status = cmd_s1.fixed_status;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SEMS; i++) begin
				exists_q[i] <= 1'b0;
				count_q[i]  <= '0;
				head_q[i]   <= '0;
				tail_q[i]   <= '0;
				fill_q[i]   <= '0;
			end
		end else if (exec_en && upd_slot) begin
			exists_q[cmd_s1.slot] <= new_exists;
			count_q[cmd_s1.slot]  <= new_count;
			head_q[cmd_s1.slot]   <= new_head;
			tail_q[cmd_s1.slot]   <= new_tail;
			fill_q[cmd_s1.slot]   <= new_fill;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_en && mem_we) wait_mem[mem_addr] <= cmd_s1.pid;
	end

	always_ff @(posedge clk) begin
		if (exec_en) mem_rd_q <= wait_mem[mem_addr];
	end

	always_ff @(posedge clk) begin
		if (q_pop) cmd_s1 <= q_cmd;
		if (exec_en) status_s2 <= exec_status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= BK_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		out_load = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (q_not_empty) begin
					q_pop   = 1'b1;
					state_d = BK_EXEC;
				end
			end
			BK_EXEC: begin
				state_d = BK_RESP;
			end
			BK_RESP: begin
				if (!rsp_valid_q || !rsp_stall) begin
					out_load = 1'b1;
					if (q_not_empty) begin
						q_pop   = 1'b1;
						state_d = BK_EXEC;
					end else begin
						state_d = BK_IDLE;
					end
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rsp_valid_q <= 1'b0;
		else if (out_load) rsp_valid_q <= 1'b1;
		else if (!rsp_stall) rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q    <= status_s2;
			woken_pid_q <= (status_s2 == STAT_WOKE) ? 8'(mem_rd_q) : 8'd0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status    = status_q;
	assign woken_pid = woken_pid_q;

endmodule

@@ src/counting_semaphore_unit.sv @@
// counting semaphore table with a fifo wait queue per slot
// request channel: req_valid/req_stall carry operation, sem_index, pid,
// init_value and process_alive; a transaction is taken when req_valid is
// high and req_stall low
// response channel: rsp_valid/rsp_stall carry status and woken_pid, one
// response for every request, in request order
// a request is classified on entry and parked in a two-entry command queue;
// the execution side reads and updates the slot state and reads the wait
// store in the EXEC state and registers the status, then loads the response
// registers in the RESP state once the response side is not stalled
// the back end works on one command at a time: it pops the next only as it
// loads the previous response, which leaves room for the read-modify-write of
// the slot state plus the registered read of the wait store
// while rsp_stall is high the response holds; the command queue then fills
// and req_stall rises until the response is taken
// reset clears the existence marks, counts and queue pointers at once; the
// wait store holds no reset value and its read data is only used where written
`include "counting_semaphore_unit_assert.svh"

module counting_semaphore_unit import csu_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic [1:0]          operation,
	input  logic [3:0]          sem_index,
	input  logic [7:0]          pid,
	input  logic signed [15:0]  init_value,
	input  logic                process_alive,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic [3:0]          status,
	output logic [7:0]          woken_pid
);

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_not_empty;
	cmd_t push_cmd;
	cmd_t head_cmd;

	csu_front u_front (
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.operation     (operation),
		.sem_index     (sem_index),
		.pid           (pid),
		.init_value    (init_value),
		.process_alive (process_alive),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_cmd         (push_cmd)
	);

	csu_cmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head_cmd  (head_cmd)
	);

	csu_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_cmd       (head_cmd),
		.q_pop       (q_pop),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.woken_pid   (woken_pid)
	);

	`CSU_ASSERT(a_wake_only_on_woke, rsp_valid && (status != STAT_WOKE) |-> woken_pid == 8'd0, "woken pid set without a wake")
	`CSU_ASSERT(a_pop_spacing, q_pop |=> !q_pop, "command queue popped on consecutive cycles")
	`CSU_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !rsp_valid, "response valid during reset")

endmodule

@@ sim/counting_semaphore_unit_checker.sv @@
module counting_semaphore_unit_checker import csu_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_stall,
	input  logic [1:0]          operation,
	input  logic [3:0]          sem_index,
	input  logic [7:0]          pid,
	input  logic signed [15:0]  init_value,
	input  logic                process_alive,
	input  logic                rsp_valid,
	input  logic                rsp_stall,
	input  logic [3:0]          status,
	input  logic [7:0]          woken_pid,
	output int                  fail_count,
	output int                  outstanding
);

	typedef struct {
		status_t             status;
		logic [PID_BITS-1:0] wake;
	} reply_t;

	// shadow copy of the semaphore table
	logic                       slot_live   [NUM_SEMS];
	logic signed [CNT_BITS-1:0] slot_count  [NUM_SEMS];
	logic [PID_BITS-1:0]        waiter_ring [NUM_SEMS][QUEUE_DEPTH];
	logic [QPTR_BITS-1:0]       ring_head   [NUM_SEMS];
	logic [QPTR_BITS-1:0]       ring_tail   [NUM_SEMS];
	logic [FILL_BITS-1:0]       ring_fill   [NUM_SEMS];

	reply_t pending_replies[$];

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		fail_count++;
	endtask

	task automatic apply_request(input logic [1:0] op, input logic [3:0] s,
			input logic [PID_BITS-1:0] who, input logic signed [CNT_BITS-1:0] start,
			input logic alive, output reply_t r);
		int  nxt;
		logic known;
		known = (int'(s) < NUM_SEMS) && slot_live[s];
		r.status = STAT_UNKNOWN;
		r.wake = '0;
		case (op)
			OP_CREATE: begin
				if (int'(s) >= NUM_SEMS) begin
					r.status = STAT_UNKNOWN;
				end else if (slot_live[s]) begin
					r.status = STAT_EXISTS;
				end else begin
					slot_live[s] = 1'b1;
					slot_count[s] = start;
					ring_head[s] = '0;
					ring_tail[s] = '0;
					ring_fill[s] = '0;
					r.status = STAT_CREATED;
				end
			end
			OP_WAIT: begin
				// a dead process is refused before the slot is looked at
				if (!alive) begin
					r.status = STAT_DEAD;
				end else if (known) begin
					nxt = int'(slot_count[s]) - 1;
					if (nxt < int'(COUNT_MIN)) begin
						nxt = int'(COUNT_MIN);
					end
					if (nxt >= 0) begin
						slot_count[s] = CNT_BITS'(nxt);
						r.status = STAT_ACQUIRED;
					end else if (int'(ring_fill[s]) >= QUEUE_DEPTH) begin
						r.status = STAT_QFULL;
					end else begin
						waiter_ring[s][ring_tail[s]] = who;
						ring_tail[s] = QPTR_BITS'((int'(ring_tail[s]) + 1) % QUEUE_DEPTH);
						ring_fill[s] = ring_fill[s] + 1'b1;
						slot_count[s] = CNT_BITS'(nxt);
						r.status = STAT_BLOCKED;
					end
				end
			end
			OP_SIGNAL: begin
				if (known) begin
					nxt = int'(slot_count[s]) + 1;
					if (nxt > int'(COUNT_MAX)) begin
						nxt = int'(COUNT_MAX);
					end
					slot_count[s] = CNT_BITS'(nxt);
					if (nxt <= 0 && ring_fill[s] != 0) begin
						r.wake = waiter_ring[s][ring_head[s]];
						ring_head[s] = QPTR_BITS'((int'(ring_head[s]) + 1) % QUEUE_DEPTH);
						ring_fill[s] = ring_fill[s] - 1'b1;
						r.status = STAT_WOKE;
					end else begin
						r.status = STAT_RELEASED;
					end
				end
			end
			default: r.status = STAT_UNKNOWN;
		endcase
	endtask

	always @(posedge clk) begin
		reply_t want;
		if (!arst_n) begin
			for (int k = 0; k < NUM_SEMS; k++) begin
				slot_live[k] = 1'b0;
				slot_count[k] = '0;
				ring_head[k] = '0;
				ring_tail[k] = '0;
				ring_fill[k] = '0;
			end
			pending_replies.delete();
		end else begin
			// response side first so a same-edge request cannot satisfy it
			if (rsp_valid && !rsp_stall) begin
				if (pending_replies.size() == 0) begin
					report_mismatch($sformatf("status %0d woken %0d with nothing outstanding",
						status, woken_pid));
				end else begin
					want = pending_replies.pop_front();
					if (status !== want.status) begin
						report_mismatch($sformatf("status %0d, expected %s",
							status, want.status.name()));
					end
					if (woken_pid !== want.wake) begin
						report_mismatch($sformatf("woken_pid %0d, expected %0d",
							woken_pid, want.wake));
					end
				end
			end
			if (req_valid && !req_stall) begin
				apply_request(operation, sem_index, pid, init_value, process_alive, want);
				pending_replies.push_back(want);
			end
		end
		outstanding <= pending_replies.size();
	end

endmodule

@@ sim/counting_semaphore_unit_tb.sv @@
module counting_semaphore_unit_tb;
	import csu_pkg::*;

	localparam logic [1:0] OP_RESERVED = 2'd3;
	localparam int RANDOM_OPS   = 2000;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 20;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               req_valid = 1'b0;
	logic               req_stall;
	logic [1:0]         operation = '0;
	logic [3:0]         sem_index = '0;
	logic [7:0]         pid = '0;
	logic signed [15:0] init_value = '0;
	logic               process_alive = 1'b0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	logic [3:0]         status;
	logic [7:0]         woken_pid;

	int fail_count;
	int outstanding;
	int cycle_count = 0;
	int burst_left = 0;
	int stall_mode = 0;
	int mode_left = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	counting_semaphore_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.operation     (operation),
		.sem_index     (sem_index),
		.pid           (pid),
		.init_value    (init_value),
		.process_alive (process_alive),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.status        (status),
		.woken_pid     (woken_pid)
	);

	counting_semaphore_unit_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.operation     (operation),
		.sem_index     (sem_index),
		.pid           (pid),
		.init_value    (init_value),
		.process_alive (process_alive),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.status        (status),
		.woken_pid     (woken_pid),
		.fail_count    (fail_count),
		.outstanding   (outstanding)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// response side: stall behaviour changes every so often
	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			mode_left <= $urandom_range(32, 200);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (stall_mode)
			0: rsp_stall <= 1'b0;
			1: rsp_stall <= ($urandom_range(0, 3) == 0);
			2: rsp_stall <= ($urandom_range(0, 3) != 0);
			default: rsp_stall <= ((cycle_count % 24) < 18);
		endcase
	end

	task automatic send_op(input logic [1:0] op, input int slot, input logic [7:0] who,
			input logic signed [15:0] start, input logic alive);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_valid <= 1'b1;
		operation <= op;
		sem_index <= 4'(slot);
		pid <= who;
		init_value <= start;
		process_alive <= alive;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	initial begin
		int                 i;
		int                 pick;
		int                 slot;
		logic [1:0]         op;
		logic [7:0]         who;
		logic signed [15:0] start;
		logic               alive;

		// assert reset once every process waits on its edge
		arst_n <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// count pinned at the top
		send_op(OP_CREATE, 0, 8'h00, COUNT_MAX, 1'b1);
		send_op(OP_SIGNAL, 0, 8'hff, 16'sh5555, 1'b0);
		send_op(OP_WAIT, 0, 8'h00, 16'sh2aaa, 1'b1);
		// count pinned at the bottom, then fill the wait queue past its depth
		send_op(OP_CREATE, 1, 8'h00, COUNT_MIN, 1'b1);
		for (i = 0; i <= QUEUE_DEPTH; i++) begin
			send_op(OP_WAIT, 1, 8'(255 - i * 15), 16'(i * 4099), 1'b1);
		end
		send_op(OP_SIGNAL, 1, 8'h00, 16'sh0000, 1'b1);
		send_op(OP_WAIT, 1, 8'h33, 16'sh0000, 1'b0);
		// slot never created
		send_op(OP_WAIT, NUM_SEMS - 1, 8'h44, 16'sh0000, 1'b1);
		send_op(OP_SIGNAL, NUM_SEMS - 1, 8'h00, 16'sh0000, 1'b1);
		send_op(OP_RESERVED, 0, 8'h12, 16'sh1234, 1'b1);
		send_op(OP_CREATE, 0, 8'h00, -16'sd5, 1'b1);

		for (i = 0; i < RANDOM_OPS; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				op = OP_CREATE;
			end else if (pick < 52) begin
				op = OP_WAIT;
			end else if (pick < 96) begin
				op = OP_SIGNAL;
			end else begin
				op = OP_RESERVED;
			end
			// a few hot slots keep the queues busy
			slot = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3)
				: $urandom_range(0, NUM_SEMS - 1);
			// top slot stays unknown for most of the run
			if (op == OP_CREATE && slot == NUM_SEMS - 1 && i < RANDOM_OPS * 9 / 10) begin
				slot = NUM_SEMS - 2;
			end
			who = 8'($urandom);
			case ($urandom_range(0, 9))
				0: start = 16'(int'(COUNT_MAX) - int'($urandom_range(0, 2)));
				1: start = 16'(int'(COUNT_MIN) + int'($urandom_range(0, 2)));
				2: start = 16'($urandom);
				default: start = 16'(int'($urandom_range(0, 6)) - 3);
			endcase
			alive = ($urandom_range(0, 9) != 0);
			send_op(op, slot, who, start, alive);
		end
		req_valid <= 1'b0;

		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
